// ===== rtl/core/cbc_pkg.sv =====
`default_nettype none

package cbc_pkg;

  localparam int unsigned RAM_DEPTH = 32768;
  localparam int unsigned LIMIT_W = 18;

  // cartridge kinds
  localparam logic [2:0] KIND_ROM      = 3'd0;
  localparam logic [2:0] KIND_MBC1     = 3'd1;
  localparam logic [2:0] KIND_MBC1_RAM = 3'd2;
  localparam logic [2:0] KIND_MBC3     = 3'd3;
  localparam logic [2:0] KIND_MBC3_RAM = 3'd4;

  // result targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;

  // access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CART_KIND = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BYTES = 1'd1;

  // register window in 0x0000-0x7FFF, selected by address bits 14:13
  localparam logic [1:0] WIN_RAM_ENABLE = 2'd0;
  localparam logic [1:0] WIN_ROM_BANK   = 2'd1;
  localparam logic [1:0] WIN_UPPER_BANK = 2'd2;
  localparam logic [1:0] WIN_MODE       = 2'd3;

  typedef struct packed {
    logic        action;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] rom_address;
    logic [14:0] ram_address;
    logic        ram_write;
    logic [7:0]  ram_data;
    logic        range_error;
    logic        ram_enabled;
  } rsp_t;

  typedef struct packed {
    logic [6:0] rom_page;
    logic [1:0] ram_page;
    logic       ram_enable;
    logic       banking_mode;
  } bank_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/cbc_decode.sv =====
`default_nettype none

module cbc_decode (
  input  wire cbc_pkg::req_t        req,
  input  wire logic [2:0]           cart_kind,
  input  wire logic [15:0]          ram_bytes,
  input  wire cbc_pkg::bank_state_t state,
  output cbc_pkg::bank_state_t      state_next,
  output cbc_pkg::rsp_t             rsp
);

  logic                        mbc1;
  logic                        mbc3;
  logic                        is_write;
  logic [15:0]                 addr;
  logic [7:0]                  v;
  logic [6:0]                  bank;
  logic [cbc_pkg::LIMIT_W-1:0] limit;
  logic [cbc_pkg::LIMIT_W-1:0] depth;
  logic [14:0]                 ram_addr;
  logic                        in_ram;

  assign mbc1     = (cart_kind == cbc_pkg::KIND_MBC1) || (cart_kind == cbc_pkg::KIND_MBC1_RAM);
  assign mbc3     = (cart_kind == cbc_pkg::KIND_MBC3) || (cart_kind == cbc_pkg::KIND_MBC3_RAM);
  assign is_write = (req.action == cbc_pkg::ACT_WRITE);
  assign addr     = req.bus_address;
  assign v        = req.write_byte;
  assign depth    = cbc_pkg::LIMIT_W'(cbc_pkg::RAM_DEPTH);
  assign limit    = ({2'b00, ram_bytes} < depth) ? {2'b00, ram_bytes} : depth;
  assign ram_addr = {state.ram_page, addr[12:0]};
  assign in_ram   = (addr[15:13] == 3'b101);
  // bank zero in the switchable window selects bank 1
  assign bank     = (state.rom_page == 7'd0) ? 7'd1 : state.rom_page;

  always_comb begin
    state_next = state;
    if (!addr[15] && is_write) begin
      case (addr[14:13])
        cbc_pkg::WIN_RAM_ENABLE: begin
          if (cart_kind == cbc_pkg::KIND_MBC1_RAM || cart_kind == cbc_pkg::KIND_MBC3_RAM) begin
            state_next.ram_enable = (v[3:0] == 4'hA);
          end
        end
        cbc_pkg::WIN_ROM_BANK: begin
          if (mbc1) begin
            state_next.rom_page = {state.rom_page[6:5], v[4:0]};
          end else if (mbc3) begin
            state_next.rom_page = v[6:0];
          end
        end
        cbc_pkg::WIN_UPPER_BANK: begin
          if (mbc1) begin
            if (state.banking_mode) begin
              state_next.ram_page = v[1:0];
            end else begin
              state_next.rom_page = {v[1:0], state.rom_page[4:0]};
            end
          end else if (mbc3) begin
            // values above 3 select the clock, which is not handled
            if (v[7:2] == 6'd0) begin
              state_next.ram_page = v[1:0];
            end
          end
        end
        default: begin
          if (cart_kind == cbc_pkg::KIND_MBC1_RAM) begin
            state_next.banking_mode = v[0];
          end
        end
      endcase
    end
  end

  always_comb begin
    rsp             = '0;
    rsp.ram_enabled = state_next.ram_enable;
    if (!addr[15]) begin
      if (!is_write) begin
        rsp.target = cbc_pkg::TGT_ROM;
        if (!addr[14]) begin
          rsp.rom_address = {7'd0, addr[13:0]};
        end else begin
          rsp.rom_address = {bank, addr[13:0]};
        end
      end
    end else if (in_ram) begin
      rsp.ram_address = ram_addr;
      if ({3'b000, ram_addr} >= limit) begin
        rsp.range_error = 1'b1;
      end else begin
        rsp.target = cbc_pkg::TGT_RAM;
        if (is_write) begin
          rsp.ram_write = 1'b1;
          rsp.ram_data  = v;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cartridge_bank_controller.sv =====
`default_nettype none

// Bank controller for ROM-only, MBC1 and MBC3 cartridges. Each item is one CPU bus access;
// the block answers with one item holding the translated ROM or external RAM address, a RAM
// write strobe with data, a RAM out-of-range flag and the RAM enable. MBC1/MBC3 writes below
// 0x8000 load the bank registers. An item passes an input register and a result register, and
// one item is taken every cycle unless the output stalls; the bank registers update as an item
// moves into the result register, so the next item already sees them. The user must write
// configuration (cart kind, RAM size) only while the block is idle; the block does not enforce it.
module cartridge_bank_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire cbc_pkg::req_t                    req,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_stall,
  output cbc_pkg::rsp_t                         rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [15:0]                      cfg_data
);

  logic                 req_q_valid;
  cbc_pkg::req_t        req_q;
  logic                 advance;
  logic [2:0]           cart_kind;
  logic [15:0]          ram_bytes;
  cbc_pkg::bank_state_t state;
  cbc_pkg::bank_state_t state_next;
  cbc_pkg::rsp_t        rsp_next;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = req_q_valid && !advance;
  assign cfg_ready = 1'b1;

  cbc_decode u_decode (
    .req        (req_q),
    .cart_kind  (cart_kind),
    .ram_bytes  (ram_bytes),
    .state      (state),
    .state_next (state_next),
    .rsp        (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_kind <= cbc_pkg::KIND_ROM;
      ram_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbc_pkg::CFG_CART_KIND: cart_kind <= cfg_data[2:0];
        cbc_pkg::CFG_RAM_BYTES: ram_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: take an item whenever the stage is free or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_q <= req;
    end
  end

  // result register and bank state advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      state     <= '0;
    end else if (advance) begin
      rsp_valid <= req_q_valid;
      if (req_q_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_q_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
